@@ rtl/assert_macros.svh @@
// Assertion macros shared by the resonator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/crps_pkg.sv @@
// Types and constants of the complex resonator plant step unit.
package crps_pkg;

   localparam int DRIVE_W = 18;
   localparam int PROBE_W = 18;
   localparam int COEF_W  = 26;
   localparam int STATE_W = 40;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic signed [STATE_W-1:0] FIELD_REAL_RESET = 40'sd58982400;
   localparam logic signed [STATE_W-1:0] FIELD_IMAG_RESET = 40'sd28573696;

   localparam logic signed [PROBE_W-1:0] PROBE_MAX = 18'sd120000;
   localparam logic signed [PROBE_W-1:0] PROBE_MIN = -18'sd120000;

   typedef enum logic [1:0] {
      REG_POLE_REAL   = 2'd0,
      REG_POLE_IMAG   = 2'd1,
      REG_COUPLE_REAL = 2'd2,
      REG_COUPLE_IMAG = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] pole_real;
      logic signed [COEF_W-1:0] pole_imag;
      logic signed [COEF_W-1:0] couple_real;
      logic signed [COEF_W-1:0] couple_imag;
   } coef_type;

   localparam coef_type COEF_RESET = '{
      pole_real:   26'sd16756144,
      pole_imag:   26'sd4211,
      couple_real: 26'sd20133,
      couple_imag: 26'sd0
   };

   // field word handed from the update stage to the probe stage
   typedef struct packed {
      logic                      valid;
      logic signed [STATE_W-1:0] field_real;
      logic signed [STATE_W-1:0] field_imag;
   } stage_type;

endpackage

@@ rtl/crps_if.sv @@
// Drive and probe channel interfaces.
interface crps_req_if import crps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive_real;
   logic signed [DRIVE_W-1:0] drive_imag;

   modport source (output valid, output drive_real, output drive_imag, input ready);
   modport sink   (input valid, input drive_real, input drive_imag, output ready);
endinterface

interface crps_rsp_if import crps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [PROBE_W-1:0] probe_real;
   logic signed [PROBE_W-1:0] probe_imag;

   modport source (output valid, output probe_real, output probe_imag, input ready);
   modport sink   (input valid, input probe_real, input probe_imag, output ready);
endinterface

@@ rtl/crps_csr.sv @@
// APB register block holding the pole and coupling coefficients.
module crps_csr import crps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output coef_type          coef
);

   coef_type                 coef_ff;
   reg_index_type            index;
   logic signed [COEF_W-1:0] rd_value;

   assign index  = reg_index_type'(paddr[CSR_AW-1:2]);
   assign pready = 1'b1;
   assign coef   = coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else if (psel && penable && pwrite) begin
         case (index)
            REG_POLE_REAL:   coef_ff.pole_real   <= pwdata[COEF_W-1:0];
            REG_POLE_IMAG:   coef_ff.pole_imag   <= pwdata[COEF_W-1:0];
            REG_COUPLE_REAL: coef_ff.couple_real <= pwdata[COEF_W-1:0];
            REG_COUPLE_IMAG: coef_ff.couple_imag <= pwdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_POLE_REAL:   rd_value = coef_ff.pole_real;
         REG_POLE_IMAG:   rd_value = coef_ff.pole_imag;
         REG_COUPLE_REAL: rd_value = coef_ff.couple_real;
         REG_COUPLE_IMAG: rd_value = coef_ff.couple_imag;
         default:         rd_value = '0;
      endcase
   end

   assign prdata = {{(CSR_DW-COEF_W){rd_value[COEF_W-1]}}, rd_value};

endmodule

@@ rtl/crps_update.sv @@
// Drive input register and complex field recurrence with saturation.
`include "assert_macros.svh"
module crps_update import crps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  coef_type                  coef,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [DRIVE_W-1:0] drive_real,
   input  logic signed [DRIVE_W-1:0] drive_imag,
   input  logic                      take,
   output stage_type                 stage
);

   localparam int X_W   = STATE_W + 1;
   localparam int CL_W  = 13;
   localparam int CH_W  = COEF_W - 12;
   localparam int SUM_W = 70;
   localparam int SH_W  = SUM_W - 24;
   localparam int DT_W  = DRIVE_W + COEF_W + 1;

   logic                      in_v_ff, in_v_in;
   logic signed [DRIVE_W-1:0] dr_ff, di_ff;
   logic                      state_v_ff, state_v_in;
   logic signed [STATE_W-1:0] cav_real_ff, cav_real_in;
   logic signed [STATE_W-1:0] cav_imag_ff, cav_imag_in;
   logic                      adv;
   logic signed [X_W-1:0]     fr, fi, nfi;
   logic signed [DT_W-1:0]    dterm_r, dterm_i;
   logic signed [SUM_W-1:0]   sum_r, sum_i;

   // x * c with c split into a signed upper part and a 12-bit lower part
   function automatic logic signed [SUM_W-1:0] mul_coef(
      input logic signed [X_W-1:0]    x,
      input logic signed [COEF_W-1:0] c
   );
      logic signed [CH_W-1:0]       ch;
      logic signed [CL_W-1:0]       cl;
      logic signed [X_W+CH_W-1:0]   ph;
      logic signed [X_W+CL_W-1:0]   pl;
      ch = c[COEF_W-1:12];
      cl = {1'b0, c[11:0]};
      ph = (X_W+CH_W)'(x) * (X_W+CH_W)'(ch);
      pl = (X_W+CL_W)'(x) * (X_W+CL_W)'(cl);
      mul_coef = (SUM_W'(ph) <<< 12) + SUM_W'(pl);
   endfunction

   function automatic logic signed [STATE_W-1:0] saturate(input logic signed [SH_W-1:0] s);
      logic signed [STATE_W-1:0] r;
      if (s[SH_W-1:STATE_W-1] != {(SH_W-STATE_W+1){s[SH_W-1]}}) begin
         r = s[SH_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
      end else begin
         r = s[STATE_W-1:0];
      end
      saturate = r;
   endfunction

   assign adv      = in_v_ff && (!state_v_ff || take);
   assign in_ready = !in_v_ff || adv;

   always_comb begin
      fr  = X_W'(cav_real_ff);
      fi  = X_W'(cav_imag_ff);
      nfi = -fi;
      dterm_r = DT_W'(DT_W'(dr_ff) * DT_W'(coef.couple_real))
              - DT_W'(DT_W'(di_ff) * DT_W'(coef.couple_imag));
      dterm_i = DT_W'(DT_W'(dr_ff) * DT_W'(coef.couple_imag))
              + DT_W'(DT_W'(di_ff) * DT_W'(coef.couple_real));
      sum_r = mul_coef(fr, coef.pole_real) + mul_coef(nfi, coef.pole_imag)
            + (SUM_W'(dterm_r) <<< 16) + (SUM_W'(1) <<< 23);
      sum_i = mul_coef(fr, coef.pole_imag) + mul_coef(fi, coef.pole_real)
            + (SUM_W'(dterm_i) <<< 16) + (SUM_W'(1) <<< 23);
      cav_real_in = adv ? saturate(sum_r[SUM_W-1:24]) : cav_real_ff;
      cav_imag_in = adv ? saturate(sum_i[SUM_W-1:24]) : cav_imag_ff;
      if (in_valid && in_ready) begin
         in_v_in = 1'b1;
      end else if (adv) begin
         in_v_in = 1'b0;
      end else begin
         in_v_in = in_v_ff;
      end
      if (adv) begin
         state_v_in = 1'b1;
      end else if (take) begin
         state_v_in = 1'b0;
      end else begin
         state_v_in = state_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff     <= 1'b0;
         state_v_ff  <= 1'b0;
         cav_real_ff <= FIELD_REAL_RESET;
         cav_imag_ff <= FIELD_IMAG_RESET;
      end else begin
         in_v_ff     <= in_v_in;
         state_v_ff  <= state_v_in;
         cav_real_ff <= cav_real_in;
         cav_imag_ff <= cav_imag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         dr_ff <= drive_real;
         di_ff <= drive_imag;
      end
   end

   assign stage.valid      = state_v_ff;
   assign stage.field_real = cav_real_ff;
   assign stage.field_imag = cav_imag_ff;

   `ASSERT_NEXT(a_field_hold, clock, reset, !adv, $stable(cav_real_ff) && $stable(cav_imag_ff))
   `ASSERT_IMPLY(a_no_overrun, clock, reset, state_v_ff && !take, !adv)
   `ASSERT_NEXT(a_word_loaded, clock, reset, in_valid && in_ready, in_v_ff)

endmodule

@@ rtl/crps_probe.sv @@
// Probe rounding and clamping with the result register.
`include "assert_macros.svh"
module crps_probe import crps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  stage_type                 stage,
   output logic                      take,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [PROBE_W-1:0] probe_real,
   output logic signed [PROBE_W-1:0] probe_imag
);

   localparam int T_W = STATE_W + 1;
   localparam int Q_W = T_W - 16;

   logic                      rsp_v_ff, rsp_v_in;
   logic signed [PROBE_W-1:0] probe_real_ff, probe_imag_ff;
   logic                      probe_in_range;

   // add one half, truncate toward zero, clamp
   function automatic logic signed [PROBE_W-1:0] round_clamp(
      input logic signed [STATE_W-1:0] v
   );
      logic signed [T_W-1:0] t;
      logic signed [Q_W-1:0] q;
      logic signed [PROBE_W-1:0] r;
      t = T_W'(v) + T_W'(32768);
      q = t[T_W-1:16];
      if (t[T_W-1] && (t[15:0] != '0)) begin
         q = q + Q_W'(1);
      end
      if (q > Q_W'(PROBE_MAX)) begin
         r = PROBE_MAX;
      end else if (q < Q_W'(PROBE_MIN)) begin
         r = PROBE_MIN;
      end else begin
         r = q[PROBE_W-1:0];
      end
      round_clamp = r;
   endfunction

   assign take = stage.valid && (!rsp_v_ff || out_ready);

   always_comb begin
      if (take) begin
         rsp_v_in = 1'b1;
      end else if (out_ready) begin
         rsp_v_in = 1'b0;
      end else begin
         rsp_v_in = rsp_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         probe_real_ff <= round_clamp(stage.field_real);
         probe_imag_ff <= round_clamp(stage.field_imag);
      end
   end

   assign out_valid  = rsp_v_ff;
   assign probe_real = probe_real_ff;
   assign probe_imag = probe_imag_ff;

   assign probe_in_range = (probe_real_ff <= PROBE_MAX) && (probe_real_ff >= PROBE_MIN)
                         && (probe_imag_ff <= PROBE_MAX) && (probe_imag_ff >= PROBE_MIN);

   `ASSERT_IMPLY(a_probe_range, clock, reset, rsp_v_ff, probe_in_range)
   `ASSERT_IMPLY(a_word_from_stage, clock, reset, $rose(rsp_v_ff), $past(stage.valid))
   `ASSERT_NEXT(a_word_held, clock, reset, rsp_v_ff && !out_ready, rsp_v_ff && $stable(probe_real_ff) && $stable(probe_imag_ff))

endmodule

@@ rtl/complex_resonator_plant_step_unit.sv @@
// Top level of the complex resonator plant step unit.
// A drive word passes the input, field and result registers in turn to become its probe word.
// Throughput: one word per cycle unless rsp stalls; the field recurrence is combinational.
// The input, field and result registers form a stall-tolerant pipeline, so a
// drive word is taken while a finished probe word still waits.
// Reset (synchronous) restores the coefficients and the field and empties the pipeline.
module complex_resonator_plant_step_unit import crps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   crps_req_if.sink          req,
   crps_rsp_if.source        rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   coef_type  coef;
   stage_type stage;
   logic      take;

   crps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef    (coef)
   );

   crps_update u_update (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .drive_real (req.drive_real),
      .drive_imag (req.drive_imag),
      .take       (take),
      .stage      (stage)
   );

   crps_probe u_probe (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .take       (take),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .probe_real (rsp.probe_real),
      .probe_imag (rsp.probe_imag)
   );

endmodule
